[hdl/vss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vss_pkg
// Shared types and constants for the voice steal selector: beat payloads,
// request kinds, play states, steal priorities and controller commands.
// ----------------------------------------------------------------------------
package vss_pkg;

   localparam int COORD_W        = 16;
   localparam int KIND_W         = 2;
   localparam int VIDX_W         = 5;
   localparam int VSTATE_W       = 2;
   localparam int DIST_W         = 34;
   localparam int PRIO_W         = 2;
   localparam int SQ_W           = 2 * COORD_W;
   localparam int ENTRY_W        = 3 * COORD_W + VSTATE_W + 1;
   localparam int NUM_VOICES_DEF = 32;
   localparam int DRAIN_CYCLES   = 3;
   localparam int DRAIN_W        = $clog2(DRAIN_CYCLES);

   localparam logic [KIND_W-1:0] KIND_VOICE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LISTENER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STEAL    = 2'd2;

   localparam logic [VSTATE_W-1:0] VOICE_PLAYING = 2'd0;
   localparam logic [VSTATE_W-1:0] VOICE_PAUSED  = 2'd1;
   localparam logic [VSTATE_W-1:0] VOICE_STOPPED = 2'd2;

   localparam logic [PRIO_W-1:0] PRIO_PAUSED   = 2'd1;
   localparam logic [PRIO_W-1:0] PRIO_PLAYING  = 2'd2;
   localparam logic [PRIO_W-1:0] PRIO_RELATIVE = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic [VIDX_W-1:0]          voice_index;
      logic [VSTATE_W-1:0]        voice_state;
      logic                       relative;
      logic                       allocated;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
      logic [DIST_W-1:0]          max_sq_distance;
      logic [PRIO_W-1:0]          priority_req;
   } req_payload_type;

   typedef struct packed {
      logic              found;
      logic [VIDX_W-1:0] victim_index;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic rd_en;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_SCAN,
      CTRL_DRAIN,
      CTRL_REPLY
   } ctrl_state_type;

endpackage

`default_nettype wire

[hdl/vss_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vss_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/vss_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vss_ctrl
// Sequencer: takes request beats, steps the voice scan, waits for the
// distance pipeline to empty and hands the reply to the datapath.
// ----------------------------------------------------------------------------
module vss_ctrl
   import vss_pkg::*;
#(
   parameter int NUM_VOICES = NUM_VOICES_DEF,
   localparam int IDX_W = $clog2(NUM_VOICES)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [KIND_W-1:0] req_kind,
   output logic                   req_stall,
   input  wire dp_status_type     status,
   output ctrl_cmd_type           cmd,
   output logic      [IDX_W-1:0]  scan_idx
);

   ctrl_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [DRAIN_W-1:0] dcnt_ff, dcnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
         cnt_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      dcnt_in   = dcnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         CTRL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_kind == KIND_STEAL) begin
                  state_in = CTRL_SCAN;
                  cnt_in   = '0;
               end else begin
                  state_in = CTRL_REPLY;
               end
            end
         end
         CTRL_SCAN: begin
            cmd.rd_en = 1'b1;
            if (cnt_ff == IDX_W'(NUM_VOICES - 1)) begin
               state_in = CTRL_DRAIN;
               dcnt_in  = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         CTRL_DRAIN: begin
            if (dcnt_ff == DRAIN_W'(DRAIN_CYCLES - 1)) begin
               state_in = CTRL_REPLY;
            end else begin
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         CTRL_REPLY: begin
            cmd.finish = 1'b1;
            if (status.out_free) begin
               state_in = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   assign scan_idx = cnt_ff;

`ifndef SYNTHESIS
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == CTRL_SCAN |-> cnt_ff <= IDX_W'(NUM_VOICES - 1))
      else $error("scan counter beyond last voice");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == CTRL_SCAN && cnt_ff == IDX_W'(NUM_VOICES - 1) |=> state_ff == CTRL_DRAIN)
      else $error("scan did not end after last voice");
`endif

endmodule

`default_nettype wire

[hdl/vss_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vss_datapath
// Voice table, listener position, distance pipeline, per-class candidate
// tracking, victim choice and reply register.
// ----------------------------------------------------------------------------
module vss_datapath
   import vss_pkg::*;
#(
   parameter int NUM_VOICES = NUM_VOICES_DEF,
   localparam int IDX_W = $clog2(NUM_VOICES)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_payload_type  req_payload,
   input  wire ctrl_cmd_type     cmd,
   input  wire logic [IDX_W-1:0] scan_idx,
   input  wire logic             rsp_stall,
   output dp_status_type         status,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload
);

   localparam int EXT_W = IDX_W + VIDX_W;

   // write decode
   logic [EXT_W-1:0]   wr_idx_ext;
   logic [IDX_W-1:0]   wr_idx;
   logic               wr_in_range;
   logic               voice_we;
   logic               listener_we;
   logic [ENTRY_W-1:0] wr_entry;

   assign wr_idx_ext  = {{IDX_W{1'b0}}, req_payload.voice_index};
   assign wr_idx      = wr_idx_ext[IDX_W-1:0];
   assign wr_in_range = wr_idx_ext < EXT_W'(NUM_VOICES);
   assign voice_we    = cmd.accept && req_payload.kind == KIND_VOICE && wr_in_range;
   assign listener_we = cmd.accept && req_payload.kind == KIND_LISTENER;
   assign wr_entry    = {req_payload.voice_state, req_payload.relative,
                         req_payload.pos_x, req_payload.pos_y, req_payload.pos_z};

   logic [ENTRY_W-1:0] rd_entry;

   vss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_VOICES)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (voice_we),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (scan_idx),
      .rd_data (rd_entry)
   );

   // allocated flags and listener
   logic [NUM_VOICES-1:0] alloc_ff, alloc_in;
   logic [COORD_W-1:0]    lis_ff [3];
   logic [COORD_W-1:0]    lis_in [3];

   // read stage
   logic             rd_valid_ff;
   logic             rd_alloc_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   logic [VSTATE_W-1:0] rd_state;
   logic                rd_rel;
   logic [COORD_W-1:0]  rd_pos [3];
   logic [COORD_W:0]    diff   [3];
   logic [COORD_W:0]    diff_n [3];
   logic [COORD_W-1:0]  mag    [3];

   // square stage
   logic                sq_valid_ff;
   logic                sq_alloc_ff;
   logic [IDX_W-1:0]    sq_idx_ff;
   logic                sq_rel_ff;
   logic [VSTATE_W-1:0] sq_state_ff;
   logic [SQ_W-1:0]     sq_ff [3];
   logic [SQ_W-1:0]     sq_in [3];

   // distance stage
   logic [DIST_W-1:0]   dist_sum;
   logic                ds_valid_ff;
   logic [IDX_W-1:0]    ds_idx_ff;
   logic                ds_rel_ff;
   logic [VSTATE_W-1:0] ds_state_ff;
   logic [DIST_W-1:0]   ds_dist_ff;

   // request context and candidates
   logic [DIST_W-1:0]   lim_ff;
   logic [PRIO_W-1:0]   prio_ff;
   logic [2:0]          have_ff, have_in;
   logic [IDX_W-1:0]    who_ff [3];
   logic [IDX_W-1:0]    who_in [3];
   logic [DIST_W-1:0]   far_ff [3];
   logic [DIST_W-1:0]   far_in [3];
   logic                have_rel_ff, have_rel_in;
   logic [IDX_W-1:0]    rel_who_ff, rel_who_in;
   logic [VSTATE_W-1:0] rel_state_ff, rel_state_in;

   // victim and reply
   logic             hit;
   logic [IDX_W-1:0] victim;
   logic [EXT_W-1:0] victim_ext;
   logic             release_voice;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   assign rd_state  = rd_entry[ENTRY_W-1 -: VSTATE_W];
   assign rd_rel    = rd_entry[3*COORD_W];
   assign rd_pos[0] = rd_entry[3*COORD_W-1 -: COORD_W];
   assign rd_pos[1] = rd_entry[2*COORD_W-1 -: COORD_W];
   assign rd_pos[2] = rd_entry[COORD_W-1:0];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a]   = {rd_pos[a][COORD_W-1], rd_pos[a]} - {lis_ff[a][COORD_W-1], lis_ff[a]};
         diff_n[a] = ~diff[a] + 1'b1;
         mag[a]    = diff[a][COORD_W] ? diff_n[a][COORD_W-1:0] : diff[a][COORD_W-1:0];
         sq_in[a]  = SQ_W'(mag[a]) * SQ_W'(mag[a]);
         lis_in[a] = lis_ff[a];
      end
      if (listener_we) begin
         lis_in[0] = req_payload.pos_x;
         lis_in[1] = req_payload.pos_y;
         lis_in[2] = req_payload.pos_z;
      end
   end

   assign dist_sum = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);

   // candidate update
   always_comb begin
      have_in      = have_ff;
      have_rel_in  = have_rel_ff;
      rel_who_in   = rel_who_ff;
      rel_state_in = rel_state_ff;
      for (int c = 0; c < 3; c++) begin
         who_in[c] = who_ff[c];
         far_in[c] = far_ff[c];
      end
      if (cmd.accept) begin
         have_in     = '0;
         have_rel_in = 1'b0;
      end else if (ds_valid_ff) begin
         if (!ds_rel_ff) begin
            for (int c = 0; c < 3; c++) begin
               if (ds_state_ff == VSTATE_W'(c) && (!have_ff[c] || far_ff[c] < ds_dist_ff)) begin
                  have_in[c] = 1'b1;
                  who_in[c]  = ds_idx_ff;
                  far_in[c]  = ds_dist_ff;
               end
            end
         end else if (!have_rel_ff || rel_state_ff < ds_state_ff) begin
            have_rel_in  = 1'b1;
            rel_who_in   = ds_idx_ff;
            rel_state_in = ds_state_ff;
         end
      end
   end

   // victim by fall-through
   always_comb begin
      hit    = 1'b0;
      victim = '0;
      if (have_ff[VOICE_STOPPED]) begin
         hit    = 1'b1;
         victim = who_ff[VOICE_STOPPED];
      end else if (prio_ff >= PRIO_PAUSED && have_ff[VOICE_PAUSED]) begin
         hit    = 1'b1;
         victim = who_ff[VOICE_PAUSED];
      end else if (prio_ff >= PRIO_PLAYING && have_ff[VOICE_PLAYING]) begin
         hit    = 1'b1;
         victim = who_ff[VOICE_PLAYING];
      end else if (prio_ff == PRIO_RELATIVE && have_rel_ff) begin
         hit    = 1'b1;
         victim = rel_who_ff;
      end
   end

   assign victim_ext      = {{VIDX_W{1'b0}}, victim};
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign release_voice   = cmd.finish && status.out_free && hit;

   always_comb begin
      alloc_in = alloc_ff;
      if (voice_we) begin
         alloc_in[wr_idx] = req_payload.allocated;
      end
      if (release_voice) begin
         alloc_in[victim] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.finish && status.out_free) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.found        = hit;
         rsp_payload_in.victim_index = victim_ext[VIDX_W-1:0];
      end else if (status.out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff     <= '0;
         lis_ff       <= '{default: '0};
         rd_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         ds_valid_ff  <= 1'b0;
         have_ff      <= '0;
         have_rel_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alloc_ff     <= alloc_in;
         lis_ff       <= lis_in;
         rd_valid_ff  <= cmd.rd_en;
         sq_valid_ff  <= rd_valid_ff;
         ds_valid_ff  <= sq_valid_ff && sq_alloc_ff && dist_sum <= lim_ff;
         have_ff      <= have_in;
         have_rel_ff  <= have_rel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rd_alloc_ff    <= alloc_ff[scan_idx];
      rd_idx_ff      <= scan_idx;
      sq_alloc_ff    <= rd_alloc_ff;
      sq_idx_ff      <= rd_idx_ff;
      sq_rel_ff      <= rd_rel;
      sq_state_ff    <= rd_state;
      sq_ff          <= sq_in;
      ds_idx_ff      <= sq_idx_ff;
      ds_rel_ff      <= sq_rel_ff;
      ds_state_ff    <= sq_state_ff;
      ds_dist_ff     <= dist_sum;
      who_ff         <= who_in;
      far_ff         <= far_in;
      rel_who_ff     <= rel_who_in;
      rel_state_ff   <= rel_state_in;
      rsp_payload_ff <= rsp_payload_in;
      if (cmd.accept) begin
         lim_ff  <= req_payload.max_sq_distance;
         prio_ff <= req_payload.priority_req;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_release_allocated: assert property (@(posedge clock) disable iff (reset)
      release_voice |-> alloc_ff[victim])
      else $error("released voice was not allocated");

   a_reply_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("reply beat without finish command");

   a_none_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.found |-> rsp_payload_ff.victim_index == '0)
      else $error("index set on a reply without a victim");
`endif

endmodule

`default_nettype wire

[hdl/voice_steal_selector_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// voice_steal_selector_unit
// Voice table with listener position; steal requests pick and release the
// farthest suitable voice by class and priority.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            beat
//  req_     in         req_valid/req_stall  req_payload_type
//  rsp_     out        rsp_valid/rsp_stall  rsp_payload_type
//
//  voice and listener writes: one reply beat each
//  steal request: one voice per cycle through the
//  single distance pipeline (read, square, sum and limit, candidate update)
//  reset clears all allocated flags and the listener position at once
//  a stalled reply holds the sequencer in its reply step; one request at a time
// ----------------------------------------------------------------------------
module voice_steal_selector_unit
   import vss_pkg::*;
#(
   parameter int NUM_VOICES = NUM_VOICES_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   localparam int IDX_W = $clog2(NUM_VOICES);

   ctrl_cmd_type     cmd;
   dp_status_type    status;
   logic [IDX_W-1:0] scan_idx;

   vss_ctrl #(
      .NUM_VOICES (NUM_VOICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .scan_idx  (scan_idx)
   );

   vss_datapath #(
      .NUM_VOICES (NUM_VOICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .scan_idx    (scan_idx),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[tb/sv/voice_steal_selector_unit_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// voice_steal_selector_unit_tb
// Self-checking bench for the voice steal selector. A short table of opening
// beats covers the empty table, coordinate extremes, every request kind,
// distance ties, the priority fall-through and relative voices. Random
// traffic follows: mostly voice writes around the listener, interleaved with
// listener moves, steal requests and unused kinds. Every reply is compared
// with a fixed expectation or a behavioural model of the voice table, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module voice_steal_selector_unit_tb;
   import vss_pkg::*;

   localparam logic [KIND_W-1:0]   KIND_UNUSED  = 2'd3;
   localparam logic [VSTATE_W-1:0] VOICE_SPARE  = 2'd3;
   localparam logic [PRIO_W-1:0]   PRIO_STOPPED = 2'd0;
   localparam logic [DIST_W-1:0]   DIST_MAX     = '1;
   localparam int                  RANDOM_BEATS = 1825;

   typedef struct {
      req_payload_type beat;
      bit              exact;
      rsp_payload_type want;
   } opening_row_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   // model of the voice table
   logic                      voice_live [NUM_VOICES_DEF];
   logic [VSTATE_W-1:0]       voice_mode [NUM_VOICES_DEF];
   logic                      voice_rel  [NUM_VOICES_DEF];
   logic signed [COORD_W-1:0] voice_at   [NUM_VOICES_DEF][3];
   logic signed [COORD_W-1:0] listener_at[3];

   rsp_payload_type replies_due[$];
   opening_row_type opening_rows[$];
   int              faults = 0;
   bit              calm   = 1'b0;

   voice_steal_selector_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   function automatic int idle_draw();
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic longint reach_sq(input int v);
      longint sum;
      longint diff;
      sum = 0;
      for (int a = 0; a < 3; a++) begin
         diff = longint'($signed(voice_at[v][a])) - longint'($signed(listener_at[a]));
         sum  = sum + diff * diff;
      end
      return sum;
   endfunction

   function automatic rsp_payload_type predict_reply(input req_payload_type b);
      rsp_payload_type r;
      bit              have[3];
      int              who[3];
      longint          far_d[3];
      bit              have_rel;
      int              rel_who;
      longint          d;
      longint          limit;
      int              s;
      int              victim;
      r        = '0;
      have     = '{0, 0, 0};
      who      = '{0, 0, 0};
      far_d    = '{0, 0, 0};
      have_rel = 1'b0;
      rel_who  = 0;
      victim   = -1;
      case (b.kind)
         KIND_VOICE: begin
            voice_mode[b.voice_index]  = b.voice_state;
            voice_rel[b.voice_index]   = b.relative;
            voice_live[b.voice_index]  = b.allocated;
            voice_at[b.voice_index][0] = b.pos_x;
            voice_at[b.voice_index][1] = b.pos_y;
            voice_at[b.voice_index][2] = b.pos_z;
         end
         KIND_LISTENER: begin
            listener_at[0] = b.pos_x;
            listener_at[1] = b.pos_y;
            listener_at[2] = b.pos_z;
         end
         KIND_STEAL: begin
            limit = longint'(b.max_sq_distance);
            for (int i = 0; i < NUM_VOICES_DEF; i++) begin
               if (voice_live[i]) begin
                  d = reach_sq(i);
                  if (d <= limit) begin
                     if (!voice_rel[i]) begin
                        s = int'(voice_mode[i]);
                        if (voice_mode[i] != VOICE_SPARE && (!have[s] || far_d[s] < d)) begin
                           have[s]  = 1'b1;
                           who[s]   = i;
                           far_d[s] = d;
                        end
                     end else if (!have_rel || voice_mode[rel_who] < voice_mode[i]) begin
                        have_rel = 1'b1;
                        rel_who  = i;
                     end
                  end
               end
            end
            if (have[VOICE_STOPPED])
               victim = who[VOICE_STOPPED];
            else if (b.priority_req >= PRIO_PAUSED && have[VOICE_PAUSED])
               victim = who[VOICE_PAUSED];
            else if (b.priority_req >= PRIO_PLAYING && have[VOICE_PLAYING])
               victim = who[VOICE_PLAYING];
            else if (b.priority_req == PRIO_RELATIVE && have_rel)
               victim = rel_who;
            if (victim >= 0) begin
               voice_live[victim] = 1'b0;
               r.found            = 1'b1;
               r.victim_index     = victim[VIDX_W-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_payload_type compose_beat(
      input logic [KIND_W-1:0] kind, input int idx, input logic [VSTATE_W-1:0] mode,
      input bit rel, input bit live, input int x, input int y, input int z,
      input logic [DIST_W-1:0] limit, input logic [PRIO_W-1:0] prio);
      req_payload_type b;
      b.kind            = kind;
      b.voice_index     = idx[VIDX_W-1:0];
      b.voice_state     = mode;
      b.relative        = rel;
      b.allocated       = live;
      b.pos_x           = x[COORD_W-1:0];
      b.pos_y           = y[COORD_W-1:0];
      b.pos_z           = z[COORD_W-1:0];
      b.max_sq_distance = limit;
      b.priority_req    = prio;
      return b;
   endfunction

   function automatic void add_row(input req_payload_type b, input bit exact,
                                   input rsp_payload_type want);
      opening_row_type row;
      row.beat  = b;
      row.exact = exact;
      row.want  = want;
      opening_rows.insert(opening_rows.size(), row);
   endfunction

   function automatic logic [COORD_W-1:0] random_coord();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return COORD_W'($urandom_range(0, 8) - 4);
      else if (pick < 78)
         return {1'b1, {(COORD_W-1){1'b0}}};
      else if (pick < 85)
         return {1'b0, {(COORD_W-1){1'b1}}};
      return COORD_W'($urandom);
   endfunction

   function automatic req_payload_type random_beat();
      req_payload_type b;
      int              pick;
      b    = $bits(req_payload_type)'({$urandom, $urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
         b.kind        = KIND_VOICE;
         b.voice_state = ($urandom_range(0, 11) == 0) ? VOICE_SPARE
                                                      : VSTATE_W'($urandom_range(0, 2));
         b.relative    = ($urandom_range(0, 4) == 0);
         b.allocated   = ($urandom_range(0, 6) != 0);
         b.pos_x       = random_coord();
         b.pos_y       = random_coord();
         b.pos_z       = random_coord();
      end else if (pick < 60) begin
         b.kind  = KIND_LISTENER;
         b.pos_x = random_coord();
         b.pos_y = random_coord();
         b.pos_z = random_coord();
      end else if (pick < 96) begin
         b.kind = KIND_STEAL;
         pick   = $urandom_range(0, 9);
         if (pick < 4)
            b.max_sq_distance = DIST_MAX;
         else if (pick < 7)
            b.max_sq_distance = DIST_W'($urandom_range(0, 300));
         else if (pick < 9)
            b.max_sq_distance = {2'($urandom_range(0, 3)), $urandom};
         else
            b.max_sq_distance = '0;
      end else begin
         b.kind = KIND_UNUSED;
      end
      return b;
   endfunction

   task automatic send_beat(input req_payload_type b, input bit exact,
                            input rsp_payload_type want);
      int              gap;
      rsp_payload_type got;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      got = predict_reply(b);
      replies_due.insert(replies_due.size(), exact ? want : got);
   endtask

   // reply check
   always @(posedge clock) begin
      rsp_payload_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (replies_due.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected reply beat: found %0b victim %0d",
                        rsp_payload.found, rsp_payload.victim_index);
         end else begin
            due = replies_due.pop_front();
            if (rsp_payload.found !== due.found ||
                rsp_payload.victim_index !== due.victim_index) begin
               faults++;
               if (faults <= 10)
                  $display("reply mismatch: expected found %0b victim %0d, got found %0b victim %0d",
                           due.found, due.victim_index,
                           rsp_payload.found, rsp_payload.victim_index);
            end
         end
      end
   end

   // reply side back-pressure
   initial begin
      int hold;
      forever begin
         hold = idle_draw();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   initial begin
      #3000000;
      $display("FAIL voice_steal_selector_unit");
      $finish;
   end

   initial begin
      rsp_payload_type none;
      none = '0;
      foreach (voice_live[i]) begin
         voice_live[i] = 1'b0;
         voice_mode[i] = VOICE_PLAYING;
         voice_rel[i]  = 1'b0;
         for (int a = 0; a < 3; a++)
            voice_at[i][a] = '0;
      end
      for (int a = 0; a < 3; a++)
         listener_at[a] = '0;

      // empty table, extremes, priority fall-through, ties, relative voices
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              DIST_MAX, PRIO_RELATIVE), 1, none);
      add_row('1, 1, none);
      add_row(compose_beat(KIND_VOICE, 31, VOICE_STOPPED, 0, 1, 32767, 32767,
              32767, '0, PRIO_STOPPED), 1, none);
      add_row(compose_beat(KIND_LISTENER, 0, VOICE_PLAYING, 0, 0, -32768,
              -32768, -32768, '0, PRIO_STOPPED), 1, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              DIST_MAX, PRIO_STOPPED), 1, '{1'b1, 5'd31});
      add_row(compose_beat(KIND_VOICE, 0, VOICE_PAUSED, 0, 1, -32768, -32768,
              -32768, '0, PRIO_STOPPED), 1, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              '0, PRIO_STOPPED), 1, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              '0, PRIO_PAUSED), 1, '{1'b1, 5'd0});
      add_row(compose_beat(KIND_LISTENER, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              '0, PRIO_STOPPED), 1, none);
      add_row(compose_beat(KIND_VOICE, 1, VOICE_PLAYING, 0, 1, 3, 4, 0,
              '0, PRIO_STOPPED), 0, none);
      add_row(compose_beat(KIND_VOICE, 2, VOICE_PLAYING, 0, 1, 0, 0, 5,
              '0, PRIO_STOPPED), 0, none);
      add_row(compose_beat(KIND_VOICE, 3, VOICE_PLAYING, 0, 1, 0, 0, 4,
              '0, PRIO_STOPPED), 0, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              34'd25, PRIO_PLAYING), 0, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              34'd24, PRIO_PLAYING), 0, none);
      add_row(compose_beat(KIND_VOICE, 4, VOICE_PLAYING, 1, 1, 100, -7, 2,
              '0, PRIO_STOPPED), 0, none);
      add_row(compose_beat(KIND_VOICE, 5, VOICE_SPARE, 1, 1, 1, 1, 1,
              '0, PRIO_STOPPED), 0, none);
      add_row(compose_beat(KIND_VOICE, 6, VOICE_STOPPED, 1, 1, -2, 0, 0,
              '0, PRIO_STOPPED), 0, none);
      add_row(compose_beat(KIND_VOICE, 7, VOICE_SPARE, 0, 1, 0, 0, 0,
              '0, PRIO_STOPPED), 0, none);
      add_row(compose_beat(KIND_VOICE, 8, VOICE_STOPPED, 0, 0, 0, 0, 0,
              '0, PRIO_STOPPED), 0, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              DIST_MAX, PRIO_RELATIVE), 0, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              DIST_MAX, PRIO_RELATIVE), 0, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              DIST_MAX, PRIO_RELATIVE), 0, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              DIST_MAX, PRIO_RELATIVE), 0, none);
      add_row(compose_beat(KIND_STEAL, 0, VOICE_PLAYING, 0, 0, 0, 0, 0,
              DIST_MAX, PRIO_RELATIVE), 0, none);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[r])
         send_beat(opening_rows[r].beat, opening_rows[r].exact, opening_rows[r].want);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if ($urandom_range(0, 59) == 0)
            calm = !calm;
         send_beat(random_beat(), 0, none);
      end
      req_valid <= 1'b0;

      wait (replies_due.size() == 0);
      repeat (NUM_VOICES_DEF + 16) @(posedge clock);
      if (faults == 0)
         $display("PASS voice_steal_selector_unit");
      else
         $display("FAIL voice_steal_selector_unit");
      $finish;
   end

endmodule

`default_nettype wire
